// ===== src/srtn_pkg.sv =====
// Shared types and fixed field widths for the SRTN schedule simulator.
// No dependencies; imported by the controller, the datapath and the top level.
package srtn_pkg;

  localparam int ARR_W      = 16;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 23;
  localparam int JOB_IDX_W  = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USED_W = JOB_IDX_W + ARR_W + BURST_W + 3 * TIME_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // write one job into the stores
    logic run_start;  // zero the clock, clear the scan results
    logic scan_rd;    // read one entry for the scan
    logic span;       // work out how far the chosen job runs
    logic update;     // advance the clock, charge the chosen job
    logic rep_rd;     // read one entry for the report
    logic rep_calc;   // form the turnaround time
    logic out_load;   // load the output register
    logic out_last;   // the item being loaded is the final report
  } srtn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic job_done;   // the chosen job finishes in this update
  } srtn_stat_t;

endpackage

// ===== src/srtn_schedule_simulator.sv =====
// Top level of the SRTN schedule simulator: stream ports, field packing.
// Depends on srtn_pkg, srtn_ctrl and srtn_dp.
//
// Each input item loads one job (arrival time, burst length; a zero burst
// counts as one unit); the item with tlast set loads its job, if there is
// room, and starts the run. Jobs beyond MAX_JOBS are dropped. The run then
// simulates preemptive shortest-remaining-time scheduling, ties going to the
// earlier arrival and then to the lower index, and finally one result item
// per job is sent in index order, tlast marking the last. Loading takes an
// item whenever one is offered. The run advances in events: each event is a
// scan of the N held jobs through one comparator, reading one store entry per
// cycle, then a span step and an update step; a run has at most 2N events
// (each job finishes once, each arrival interrupts once). Each job's report
// passes a store read, the turnaround step and the output register, which
// waits while the sink stalls. No input is taken from the last item until the
// final result sits in the output register, after which loading resumes while
// that result waits to be taken.
module srtn_schedule_simulator import srtn_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // arrival_time, burst_length
  input  logic                  in_tlast,   // is_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // job_index, arrival_echo, burst_echo, completion_time, turnaround_time,
  // waiting_time, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // final_report
);

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  srtn_cmd_t            cmd;
  srtn_stat_t           stat;
  logic [IW-1:0]        addr;
  logic [JOB_IDX_W-1:0] o_idx;
  logic [ARR_W-1:0]     o_arr;
  logic [BURST_W-1:0]   o_burst;
  logic [TIME_W-1:0]    o_comp, o_tat, o_wait;

  srtn_ctrl #(
    .MAX_JOBS (MAX_JOBS),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd),
    .addr       (addr)
  );

  srtn_dp #(
    .MAX_JOBS (MAX_JOBS),
    .IW       (IW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .addr        (addr),
    .in_arrival  (in_tdata[ARR_W-1:0]),
    .in_burst    (in_tdata[ARR_W+BURST_W-1:ARR_W]),
    .stat        (stat),
    .out_idx     (o_idx),
    .out_arrival (o_arr),
    .out_burst   (o_burst),
    .out_comp    (o_comp),
    .out_tat     (o_tat),
    .out_wait    (o_wait),
    .out_last    (out_tlast)
  );

  // pack fields from the lowest bit up
  assign out_tdata = {OUT_PAD_W'(0), o_wait, o_tat, o_comp, o_burst, o_arr, o_idx};

  // store port is shared: one access kind per cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_rd, cmd.rep_rd}))
    else $error("store accessed for two purposes at once");

  // a job is written only for an accepted item
  a_load_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_tvalid && in_tready))
    else $error("job loaded without an accepted item");

  // the last item starts the run, so loading stops
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still taken after the last item");

  // a loaded result is offered on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("output register loaded but not offered");

endmodule

// ===== src/srtn_ctrl.sv =====
// Sequencer of the SRTN schedule simulator: load, scan, span, update, report.
// Depends on srtn_pkg; drives the command struct of srtn_dp.
module srtn_ctrl import srtn_pkg::*; #(
  parameter int MAX_JOBS = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  logic          out_tready,
  output logic          out_tvalid,
  input  srtn_stat_t    stat,
  output srtn_cmd_t     cmd,
  output logic [IW-1:0] addr
);

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_SPAN, S_UPDATE, S_RD, S_CALC, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] fin_cnt_r, fin_cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic          last_job;

  assign last_job   = (idx_r == cnt_r - CW'(1));
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_vld_r;
  assign addr       = (state_r == S_LOAD) ? cnt_r[IW-1:0] : idx_r[IW-1:0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    fin_cnt_nxt = fin_cnt_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    out_vld_nxt = out_vld_r & ~out_tready;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          // drop the job when the stores are full
          if (cnt_r < CW'(MAX_JOBS)) begin
            cmd.load = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
          if (in_tlast) begin
            cmd.run_start = 1'b1;
            fin_cnt_nxt   = '0;
            idx_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < cnt_r) begin
          cmd.scan_rd = 1'b1;
          idx_nxt     = idx_r + CW'(1);
        end else begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_SCAN;
        if (stat.job_done) begin
          fin_cnt_nxt = fin_cnt_r + CW'(1);
          if (fin_cnt_r + CW'(1) == cnt_r) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        cmd.rep_calc = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_job;
          out_vld_nxt  = 1'b1;
          if (last_job) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      fin_cnt_r <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      fin_cnt_r <= fin_cnt_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== src/srtn_dp.sv =====
// Datapath of the SRTN schedule simulator: job stores, scan comparator,
// scheduling clock and report arithmetic. Depends on srtn_pkg.
module srtn_dp import srtn_pkg::*; #(
  parameter int MAX_JOBS = 16,
  parameter int IW       = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srtn_cmd_t            cmd,
  input  logic [IW-1:0]        addr,
  input  logic [ARR_W-1:0]     in_arrival,
  input  logic [BURST_W-1:0]   in_burst,
  output srtn_stat_t           stat,
  output logic [JOB_IDX_W-1:0] out_idx,
  output logic [ARR_W-1:0]     out_arrival,
  output logic [BURST_W-1:0]   out_burst,
  output logic [TIME_W-1:0]    out_comp,
  output logic [TIME_W-1:0]    out_tat,
  output logic [TIME_W-1:0]    out_wait,
  output logic                 out_last
);

  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [BURST_W-1:0] rem_mem   [MAX_JOBS];
  logic [TIME_W-1:0]  fin_mem   [MAX_JOBS];

  logic [ARR_W-1:0]    arr_q;
  logic [BURST_W-1:0]  burst_q, rem_q;
  logic [TIME_W-1:0]   fin_q;
  logic [IW-1:0]       rd_idx_r;
  logic                scan_vld_r;
  logic [MAX_JOBS-1:0] done_flag_r;

  logic [TIME_W-1:0]  clock_r;
  logic               best_vld_r;
  logic [IW-1:0]      best_idx_r;
  logic [BURST_W-1:0] best_rem_r;
  logic [ARR_W-1:0]   best_arr_r;
  logic               nxt_vld_r;
  logic [ARR_W-1:0]   nxt_arr_r;
  logic [BURST_W-1:0] span_r;
  logic               fin_now_r;
  logic [TIME_W-1:0]  tat_r;

  logic [BURST_W-1:0] burst_fix;
  logic               is_done, is_ready, is_future, better, sooner;
  logic [TIME_W-1:0]  gap, clock_sum;
  logic               take_gap;
  logic [BURST_W-1:0] rem_new;

  // zero burst runs as one unit
  assign burst_fix = (in_burst == '0) ? BURST_W'(1) : in_burst;

  assign is_done   = done_flag_r[rd_idx_r];
  assign is_ready  = !is_done && (TIME_W'(arr_q) <= clock_r);
  assign is_future = !is_done && (TIME_W'(arr_q) > clock_r);
  assign better    = !best_vld_r || (rem_q < best_rem_r) ||
                     ((rem_q == best_rem_r) && (arr_q < best_arr_r));
  assign sooner    = !nxt_vld_r || (arr_q < nxt_arr_r);

  assign gap       = TIME_W'(nxt_arr_r) - clock_r;
  assign take_gap  = nxt_vld_r && (gap < TIME_W'(best_rem_r));
  assign clock_sum = clock_r + TIME_W'(span_r);
  assign rem_new   = best_rem_r - span_r;

  assign stat.job_done = cmd.update && best_vld_r && fin_now_r;

  // stores, written and read in one clocked block
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_mem[addr]   <= in_arrival;
      burst_mem[addr] <= burst_fix;
      rem_mem[addr]   <= burst_fix;
    end else if (cmd.update && best_vld_r) begin
      rem_mem[best_idx_r] <= rem_new;
    end
    if (stat.job_done) begin
      fin_mem[best_idx_r] <= clock_sum;
    end
    if (cmd.scan_rd || cmd.rep_rd) begin
      arr_q    <= arr_mem[addr];
      burst_q  <= burst_mem[addr];
      rem_q    <= rem_mem[addr];
      fin_q    <= fin_mem[addr];
      rd_idx_r <= addr;
    end
  end

  // scan results, done flags and clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r  <= 1'b0;
      done_flag_r <= '0;
      best_vld_r  <= 1'b0;
      nxt_vld_r   <= 1'b0;
      clock_r     <= '0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        done_flag_r[addr] <= 1'b0;
      end else if (stat.job_done) begin
        done_flag_r[best_idx_r] <= 1'b1;
      end
      if (cmd.run_start) begin
        clock_r <= '0;
      end else if (cmd.update) begin
        // advance by the span; in an idle stretch jump to the next arrival
        clock_r <= best_vld_r ? clock_sum : TIME_W'(nxt_arr_r);
      end
      if (cmd.run_start || cmd.update) begin
        best_vld_r <= 1'b0;
        nxt_vld_r  <= 1'b0;
      end else if (scan_vld_r) begin
        if (is_ready && better) begin
          best_vld_r <= 1'b1;
        end
        if (is_future && sooner) begin
          nxt_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_vld_r && is_ready && better) begin
      best_idx_r <= rd_idx_r;
      best_rem_r <= rem_q;
      best_arr_r <= arr_q;
    end
    if (scan_vld_r && is_future && sooner) begin
      nxt_arr_r <= arr_q;
    end
    if (cmd.span) begin
      // run until the job ends or the next arrival, whichever comes first
      span_r    <= take_gap ? gap[BURST_W-1:0] : best_rem_r;
      fin_now_r <= !take_gap;
    end
    if (cmd.rep_calc) begin
      tat_r <= fin_q - TIME_W'(arr_q);
    end
    if (cmd.out_load) begin
      out_idx     <= JOB_IDX_W'(rd_idx_r);
      out_arrival <= arr_q;
      out_burst   <= burst_q;
      out_comp    <= fin_q;
      out_tat     <= tat_r;
      out_wait    <= tat_r - TIME_W'(burst_q);
      out_last    <= cmd.out_last;
    end
  end

endmodule

// ===== verif/srtn_sched_checker.sv =====
// Checker for the SRTN schedule simulator: watches both stream channels,
// predicts the per-job reports and compares them. Depends on srtn_pkg.
`timescale 1ns / 1ps

module srtn_sched_checker import srtn_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    pending
);

  localparam int ARR_LSB   = JOB_IDX_W;
  localparam int BURST_LSB = ARR_LSB + ARR_W;
  localparam int DONE_LSB  = BURST_LSB + BURST_W;
  localparam int TURN_LSB  = DONE_LSB + TIME_W;
  localparam int WAIT_LSB  = TURN_LSB + TIME_W;

  typedef struct {
    bit [JOB_IDX_W-1:0] idx;
    bit [ARR_W-1:0]     arr;
    bit [BURST_W-1:0]   burst;
    bit [TIME_W-1:0]    done_at;
    bit [TIME_W-1:0]    turnaround;
    bit [TIME_W-1:0]    waited;
    bit                 final_rep;
  } job_report_t;

  job_report_t      report_q[$];
  bit [ARR_W-1:0]   held_arr[MAX_JOBS];
  bit [BURST_W-1:0] held_burst[MAX_JOBS];
  bit [BURST_W-1:0] left_units[MAX_JOBS];
  bit [TIME_W-1:0]  done_tab[MAX_JOBS];
  bit               done_flag[MAX_JOBS];
  int               held = 0;
  int               fail_cnt = 0;
  int               queued = 0;

  assign mismatches = fail_cnt;
  assign pending    = queued;

  // Store one job if there is room; on the last item of a set play out the
  // schedule and queue one report per held job.
  task automatic load_job(input bit [ARR_W-1:0] a, input bit [BURST_W-1:0] b,
                          input bit last_job);
    job_report_t r;
    int unsigned now, nxt, span;
    int          fin_cnt, pick;
    bit          has_next;
    if (b == '0) b = BURST_W'(1);
    if (held < MAX_JOBS) begin
      held_arr[held]   = a;
      held_burst[held] = b;
      left_units[held] = b;
      done_flag[held]  = 1'b0;
      held++;
    end
    if (!last_job) return;

    now = 0;
    fin_cnt = 0;
    while (fin_cnt < held) begin
      pick = -1;
      has_next = 1'b0;
      nxt = 0;
      for (int i = 0; i < held; i++) begin
        if (!done_flag[i]) begin
          if (32'(held_arr[i]) <= now) begin
            if (pick < 0 || left_units[i] < left_units[pick] ||
                (left_units[i] == left_units[pick] && held_arr[i] < held_arr[pick]))
              pick = i;
          end else if (!has_next || 32'(held_arr[i]) < nxt) begin
            nxt = 32'(held_arr[i]);
            has_next = 1'b1;
          end
        end
      end
      if (pick < 0) begin
        // nothing ready: jump to the next arrival
        now = nxt;
      end else begin
        // run the chosen job until it ends or the next arrival can preempt it
        span = 32'(left_units[pick]);
        if (has_next && nxt - now < span) span = nxt - now;
        now += span;
        left_units[pick] = left_units[pick] - BURST_W'(span);
        if (left_units[pick] == '0) begin
          done_flag[pick] = 1'b1;
          done_tab[pick]  = TIME_W'(now);
          fin_cnt++;
        end
      end
    end

    for (int i = 0; i < held; i++) begin
      r.idx        = JOB_IDX_W'(i);
      r.arr        = held_arr[i];
      r.burst      = held_burst[i];
      r.done_at    = done_tab[i];
      r.turnaround = done_tab[i] - TIME_W'(held_arr[i]);
      r.waited     = r.turnaround - TIME_W'(held_burst[i]);
      r.final_rep  = (i == held - 1);
      report_q.push_back(r);
    end
    held = 0;
  endtask

  task automatic check_report();
    job_report_t want, got;
    bit          bad;
    got.idx        = out_tdata[JOB_IDX_W-1:0];
    got.arr        = out_tdata[ARR_LSB +: ARR_W];
    got.burst      = out_tdata[BURST_LSB +: BURST_W];
    got.done_at    = out_tdata[DONE_LSB +: TIME_W];
    got.turnaround = out_tdata[TURN_LSB +: TIME_W];
    got.waited     = out_tdata[WAIT_LSB +: TIME_W];
    got.final_rep  = out_tlast;
    if (report_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: unexpected report: job %0d completion %0d last %0b",
                 $realtime, got.idx, got.done_at, got.final_rep);
      return;
    end
    want = report_q.pop_front();
    bad = (got.idx != want.idx) || (got.arr != want.arr) || (got.burst != want.burst) ||
          (got.done_at != want.done_at) || (got.turnaround != want.turnaround) ||
          (got.waited != want.waited) || (got.final_rep != want.final_rep);
    if (bad) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("%0t: report mismatch (job/arr/burst/done/tat/wait/last)", $realtime);
        $display("  expected %0d %0d %0d %0d %0d %0d %0b", want.idx, want.arr, want.burst,
                 want.done_at, want.turnaround, want.waited, want.final_rep);
        $display("  actual   %0d %0d %0d %0d %0d %0d %0b", got.idx, got.arr, got.burst,
                 got.done_at, got.turnaround, got.waited, got.final_rep);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready)
        load_job(in_tdata[ARR_W-1:0], in_tdata[ARR_W +: BURST_W], in_tlast);
    end
    queued <= report_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the SRTN schedule simulator testbench: clock, reset, job stimulus,
// sink stalls and verdict. Depends on srtn_pkg, srtn_sched_checker and the RTL.
`timescale 1ns / 1ps

module tb_top import srtn_pkg::*; ();

  localparam int MAX_JOBS     = 16;
  localparam int CLK_HALF     = 6;
  localparam int TARGET_ITEMS = 210;
  localparam int CYCLE_LIMIT  = 400000;
  // a full 16-job run has at most 2 * 16 events plus the report
  localparam int DRAIN_CYCLES = 800;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int mismatches;
  int pending;
  int cycles     = 0;
  int burst_left = 0;
  int sent       = 0;
  int set_size;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  srtn_schedule_simulator #(.MAX_JOBS(MAX_JOBS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  srtn_sched_checker #(.MAX_JOBS(MAX_JOBS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sink stalls: rotate through always-ready, coin-toss, mostly-stalled and a
  // fixed duty pattern so that back-pressure lands on every report phase.
  always @(posedge clk) begin
    case ((cycles / 250) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= ((cycles % 16) < 5);
    endcase
  end

  // Send one job item and hold it until it is taken. Items go out in bursts;
  // between bursts drop tvalid for a random gap, now and then a long one so
  // that gaps also fall while a run or the report is in progress.
  task automatic push_job(input bit [ARR_W-1:0] arr, input bit [BURST_W-1:0] burst,
                          input bit last_job);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {burst, arr};
    in_tlast  <= last_job;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Hold off the sender until every queued report has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One job set with random content; the final item carries tlast.
  // Arrival spread: tight cluster, moderate, or full range (idle stretches).
  task automatic push_random_set(input int njobs);
    int               arr_mode, burst_mode;
    bit [ARR_W-1:0]   a;
    bit [BURST_W-1:0] b;
    arr_mode   = $urandom_range(0, 2);
    burst_mode = $urandom_range(0, 2);
    for (int j = 0; j < njobs; j++) begin
      case (arr_mode)
        0:       a = ARR_W'($urandom_range(0, 7));
        1:       a = ARR_W'($urandom_range(0, 300));
        default: a = ARR_W'($urandom_range(0, 65535));
      endcase
      case (burst_mode)
        0:       b = BURST_W'($urandom_range(0, 20));
        1:       b = BURST_W'($urandom_range(0, 65535));
        default: b = ($urandom_range(0, 3) == 0) ? 16'd0 :
                     BURST_W'($urandom_range(1, 65535));
      endcase
      push_job(a, b, j == njobs - 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Single job with a zero burst: runs as one unit.
    push_job(16'd0, 16'd0, 1'b1);

    // Preemption by a shorter arrival, a tie broken by index, an idle stretch and
    // the field extremes.
    push_job(16'd0,     16'd10,    1'b0);
    push_job(16'd1,     16'd2,     1'b0);
    push_job(16'd5,     16'd3,     1'b0);
    push_job(16'd5,     16'd3,     1'b0);
    push_job(16'd100,   16'd5,     1'b0);
    push_job(16'd65535, 16'd65535, 1'b0);
    push_job(16'd65535, 16'd0,     1'b1);

    // Store full: the seventeenth job, flagged last, is dropped but starts the run.
    for (int j = 0; j < MAX_JOBS + 1; j++)
      push_job(ARR_W'($urandom_range(0, 40)), BURST_W'($urandom_range(0, 30)),
               j == MAX_JOBS);

    // Let every report come back before the random part.
    wait_drained();

    while (sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 7) == 0) set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      else                           set_size = $urandom_range(1, MAX_JOBS);
      push_random_set(set_size);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
